// File: rtl/core/aht_pkg.sv
// ----------------------------------------------------------------------------
// aht_pkg
// Shared widths, constants and types of the averaging thermostat core.
// ----------------------------------------------------------------------------
`default_nettype none

package aht_pkg;

  localparam int ADC_BITS     = 10;
  localparam int CNT_BITS     = 8;
  localparam int SUM_BITS     = ADC_BITS + CNT_BITS;
  localparam int TEMP_BITS    = 9;
  localparam int SCALE_NUM    = 32031;
  localparam int SCALE_BITS   = 15;
  localparam int SCALE_SHIFT  = 16;
  localparam int PROD_BITS    = SUM_BITS + SCALE_BITS;
  localparam int SCALED_BITS  = PROD_BITS - SCALE_SHIFT;
  localparam int DIV_CNT_BITS = $clog2(SCALED_BITS);

  localparam int IN_TDATA_BITS   = ((2 * ADC_BITS + 7) / 8) * 8;
  localparam int OUT_FIELD_BITS  = 2 * TEMP_BITS + 2;
  localparam int OUT_TDATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;

  localparam int ADDR_BITS = 4;
  localparam int DATA_BITS = 32;

  localparam logic [1:0] REG_UPPER = 2'd0;
  localparam logic [1:0] REG_LOWER = 2'd1;
  localparam logic [1:0] REG_BATCH = 2'd2;

  localparam logic [TEMP_BITS-1:0] UPPER_RST = TEMP_BITS'(30);
  localparam logic [TEMP_BITS-1:0] LOWER_RST = TEMP_BITS'(25);
  localparam logic [CNT_BITS-1:0]  BATCH_RST = CNT_BITS'(100);

  typedef struct packed {
    logic acc_en;
    logic batch_end;
    logic mul;
    logic div_step;
  } lane_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/core/averaging_hysteresis_thermostat_core.sv
// ----------------------------------------------------------------------------
// averaging_hysteresis_thermostat_core
// Two-channel averaging thermostat with alarm and heater hysteresis.
// ----------------------------------------------------------------------------
// A sample pair that does not close a batch is taken at once and the core
// stays ready. The pair that closes a batch starts a conversion: a multiply
// state, 17 divide steps and a merge state, after which the core accepts its
// next request, later only if the previous result has not yet been taken.
// The conversion length is set by the one-bit-per-cycle restoring divider in
// each of the two channel lanes.
`default_nettype none

module averaging_hysteresis_thermostat_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // sample_a, sample_b, zero pad
  input  logic [aht_pkg::IN_TDATA_BITS-1:0]   s_axis_tdata,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // temp_a, temp_b, alarm_on, heater_on, zero pad
  output logic [aht_pkg::OUT_TDATA_BITS-1:0]  m_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [aht_pkg::ADDR_BITS-1:0]       paddr,
  input  logic [aht_pkg::DATA_BITS-1:0]       pwdata,
  output logic [aht_pkg::DATA_BITS-1:0]       prdata,
  output logic                                pready
);
  import aht_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_MUL   = 4'b0010,
    ST_DIV   = 4'b0100,
    ST_MERGE = 4'b1000
  } state_e;

  state_e                  state_q, state_d;
  logic [TEMP_BITS-1:0]    upper_q, lower_q;
  logic [CNT_BITS-1:0]     batch_q;
  logic [CNT_BITS-1:0]     cnt_q, cnt_d;
  logic [CNT_BITS-1:0]     cnt_new;
  logic [CNT_BITS-1:0]     n_eff;
  logic [CNT_BITS-1:0]     div_n_q;
  logic [DIV_CNT_BITS-1:0] step_q, step_d;
  logic                    accept;
  logic                    batch_end;
  logic                    cfg_wr;
  logic [1:0]              reg_idx;
  lane_ctrl_t              ctrl;
  logic [SCALED_BITS-1:0]  quot_a, quot_b;
  logic                    merge_free;
  logic                    load;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upper_q <= UPPER_RST;
      lower_q <= LOWER_RST;
      batch_q <= BATCH_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_UPPER: upper_q <= pwdata[TEMP_BITS-1:0];
        REG_LOWER: lower_q <= pwdata[TEMP_BITS-1:0];
        REG_BATCH: batch_q <= pwdata[CNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_UPPER: prdata = DATA_BITS'(upper_q);
      REG_LOWER: prdata = DATA_BITS'(lower_q);
      REG_BATCH: prdata = DATA_BITS'(batch_q);
      default:   prdata = '0;
    endcase
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cnt_new       = cnt_q + CNT_BITS'(1);
  assign n_eff         = (batch_q == '0) ? CNT_BITS'(1) : batch_q;
  assign batch_end     = (cnt_new == '0) || (cnt_new >= n_eff);
  assign load          = (state_q == ST_MERGE) && merge_free;

  assign ctrl.acc_en    = accept;
  assign ctrl.batch_end = batch_end;
  assign ctrl.mul       = (state_q == ST_MUL);
  assign ctrl.div_step  = (state_q == ST_DIV);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    step_d  = step_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cnt_d = batch_end ? '0 : cnt_new;
          if (batch_end) begin
            state_d = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        step_d  = '0;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        step_d = step_q + DIV_CNT_BITS'(1);
        if (step_q == DIV_CNT_BITS'(SCALED_BITS - 1)) begin
          state_d = ST_MERGE;
        end
      end
      ST_MERGE: begin
        if (merge_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && batch_end) begin
      div_n_q <= n_eff;
    end
  end

  aht_lane u_lane_a (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (ctrl),
    .sample_i  (s_axis_tdata[ADC_BITS-1:0]),
    .divisor_i (div_n_q),
    .quot_o    (quot_a)
  );

  aht_lane u_lane_b (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (ctrl),
    .sample_i  (s_axis_tdata[2*ADC_BITS-1:ADC_BITS]),
    .divisor_i (div_n_q),
    .quot_o    (quot_b)
  );

  aht_merge u_merge (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (load),
    .quot_a_i     (quot_a),
    .quot_b_i     (quot_b),
    .upper_i      (upper_q),
    .lower_i      (lower_q),
    .out_tready_i (m_axis_tready),
    .out_tvalid_o (m_axis_tvalid),
    .out_tdata_o  (m_axis_tdata),
    .free_o       (merge_free)
  );

endmodule

`default_nettype wire

// File: rtl/core/aht_lane.sv
// ----------------------------------------------------------------------------
// aht_lane
// One sensor channel: accumulator, scaling multiply and bit-serial divider.
// ----------------------------------------------------------------------------
`default_nettype none

module aht_lane (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  aht_pkg::lane_ctrl_t                 ctrl_i,
  input  logic [aht_pkg::ADC_BITS-1:0]        sample_i,
  input  logic [aht_pkg::CNT_BITS-1:0]        divisor_i,
  output logic [aht_pkg::SCALED_BITS-1:0]     quot_o
);
  import aht_pkg::*;

  logic [SUM_BITS-1:0]    acc_q, acc_d;
  logic [SUM_BITS-1:0]    sum_new;
  logic [SUM_BITS-1:0]    hold_q;
  logic [PROD_BITS-1:0]   prod;
  logic [SCALED_BITS-1:0] quo_q;
  logic [CNT_BITS-1:0]    rem_q;
  logic [CNT_BITS:0]      rem_sh;
  logic [CNT_BITS:0]      rem_sub;
  logic                   fits;

  assign sum_new = acc_q + SUM_BITS'(sample_i);
  assign prod    = PROD_BITS'(hold_q) * PROD_BITS'(SCALE_NUM);
  assign rem_sh  = {rem_q, quo_q[SCALED_BITS-1]};
  assign rem_sub = rem_sh - {1'b0, divisor_i};
  assign fits    = rem_sh >= {1'b0, divisor_i};

  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.acc_en) begin
      acc_d = ctrl_i.batch_end ? '0 : sum_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.acc_en && ctrl_i.batch_end) begin
      hold_q <= sum_new;
    end
    if (ctrl_i.mul) begin
      quo_q <= prod[PROD_BITS-1:SCALE_SHIFT];
      rem_q <= '0;
    end else if (ctrl_i.div_step) begin
      quo_q <= {quo_q[SCALED_BITS-2:0], fits};
      rem_q <= fits ? rem_sub[CNT_BITS-1:0] : rem_sh[CNT_BITS-1:0];
    end
  end

  assign quot_o = quo_q;

endmodule

`default_nettype wire

// File: rtl/core/aht_merge.sv
// ----------------------------------------------------------------------------
// aht_merge
// Combines both channel readings: saturation, hysteresis and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module aht_merge (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 load_i,
  input  logic [aht_pkg::SCALED_BITS-1:0]      quot_a_i,
  input  logic [aht_pkg::SCALED_BITS-1:0]      quot_b_i,
  input  logic [aht_pkg::TEMP_BITS-1:0]        upper_i,
  input  logic [aht_pkg::TEMP_BITS-1:0]        lower_i,
  input  logic                                 out_tready_i,
  output logic                                 out_tvalid_o,
  output logic [aht_pkg::OUT_TDATA_BITS-1:0]   out_tdata_o,
  output logic                                 free_o
);
  import aht_pkg::*;

  logic [TEMP_BITS-1:0]      temp_a, temp_b;
  logic                      alarm_q, alarm_d;
  logic                      heater_q, heater_d;
  logic                      valid_q, valid_d;
  logic [OUT_FIELD_BITS-1:0] data_q;

  function automatic logic [TEMP_BITS-1:0] sat(input logic [SCALED_BITS-1:0] v);
    logic over;
    over = |v[SCALED_BITS-1:TEMP_BITS];
    return over ? '1 : v[TEMP_BITS-1:0];
  endfunction

  assign temp_a = sat(quot_a_i);
  assign temp_b = sat(quot_b_i);
  assign free_o = !valid_q || out_tready_i;

  always_comb begin
    alarm_d  = alarm_q;
    heater_d = heater_q;
    valid_d  = valid_q && !out_tready_i;
    if (load_i) begin
      valid_d = 1'b1;
      if ((temp_a > upper_i || temp_b > upper_i) && !alarm_q) begin
        alarm_d  = 1'b1;
        heater_d = 1'b0;
      end else if (temp_a < upper_i && temp_b < upper_i && alarm_q) begin
        alarm_d = 1'b0;
      end else if (temp_a < lower_i && temp_b < lower_i && !alarm_q) begin
        heater_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alarm_q  <= 1'b0;
      heater_q <= 1'b0;
      valid_q  <= 1'b0;
    end else begin
      alarm_q  <= alarm_d;
      heater_q <= heater_d;
      valid_q  <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= {heater_d, alarm_d, temp_b, temp_a};
    end
  end

  assign out_tvalid_o = valid_q;
  assign out_tdata_o  = OUT_TDATA_BITS'(data_q);

endmodule

`default_nettype wire

// File: rtl/core/aht_checker.sv
// ----------------------------------------------------------------------------
// aht_checker
// Port-level checks of the thermostat core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module aht_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  input  logic                                s_axis_tready,
  input  logic [aht_pkg::OUT_TDATA_BITS-1:0]  m_axis_tdata,
  input  logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pready
);
  import aht_pkg::*;

  localparam int ALARM_BIT  = 2 * TEMP_BITS;
  localparam int HEATER_BIT = 2 * TEMP_BITS + 1;

  // result held until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped or changed while stalled");

  // heater is never driven while the alarm is active
  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[ALARM_BIT] && m_axis_tdata[HEATER_BIT]))
    else $error("alarm and heater both on");

  // input side only stalls after taking a request
  a_ready_fall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(s_axis_tready) |-> $past(s_axis_tvalid))
    else $error("input stalled without a request");

  // config port never inserts wait states
  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable |-> pready)
    else $error("config access stalled");

endmodule

bind averaging_hysteresis_thermostat_core aht_checker u_aht_checker (.*);

`default_nettype wire
